@@ rtl/assert_macros.svh @@
// Assertion macros for the file that checks the block's own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AI2D_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AI2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/ai2d_pkg.sv @@
// Shared constants and types of the affine inverse block.
package ai2d_pkg;

    // Six coefficients in, six coefficients out.
    localparam int NUM_LANES  = 6;
    localparam int FIELD_BITS = 32;

    // Control that travels down the pipeline with each request.
    typedef struct packed {
        logic valid;
        logic sing;
    } ai2d_ctl_t;

endpackage

@@ rtl/ai2d_if.sv @@
// Handshake interfaces for the matrix request and the inverse result.
interface ai2d_in_if
    import ai2d_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] coef_a;
    logic signed [FIELD_BITS-1:0] coef_b;
    logic signed [FIELD_BITS-1:0] coef_c;
    logic signed [FIELD_BITS-1:0] coef_d;
    logic signed [FIELD_BITS-1:0] offset_x;
    logic signed [FIELD_BITS-1:0] offset_y;

    modport source (
        output valid, coef_a, coef_b, coef_c, coef_d, offset_x, offset_y,
        input  ready
    );
    modport sink (
        input  valid, coef_a, coef_b, coef_c, coef_d, offset_x, offset_y,
        output ready
    );
endinterface

interface ai2d_out_if
    import ai2d_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] inv_a;
    logic signed [FIELD_BITS-1:0] inv_b;
    logic signed [FIELD_BITS-1:0] inv_c;
    logic signed [FIELD_BITS-1:0] inv_d;
    logic signed [FIELD_BITS-1:0] inv_offset_x;
    logic signed [FIELD_BITS-1:0] inv_offset_y;
    logic                         singular;
    logic                         overflow;

    modport source (
        output valid, inv_a, inv_b, inv_c, inv_d, inv_offset_x, inv_offset_y,
               singular, overflow,
        input  ready
    );
    modport sink (
        input  valid, inv_a, inv_b, inv_c, inv_d, inv_offset_x, inv_offset_y,
               singular, overflow,
        output ready
    );
endinterface

@@ rtl/ai2d_front.sv @@
// Front end: products, determinant, numerator magnitudes and quotient signs.
module ai2d_front
    import ai2d_pkg::*;
#(
    parameter  int COEF_BITS = 32,
    parameter  int FRAC_BITS = 16,
    localparam int PW        = 2 * COEF_BITS,
    localparam int NW        = PW + 2 * FRAC_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [NUM_LANES-1:0][FIELD_BITS-1:0]  in_word,
    output ai2d_ctl_t                             ctl,
    output logic [NUM_LANES-1:0][COEF_BITS-1:0]   coef,
    output logic [NUM_LANES-1:0][NW-1:0]          num_mag,
    output logic [NUM_LANES-1:0]                  qneg,
    output logic [PW-1:0]                         dmag
);

    logic signed [COEF_BITS-1:0] sx   [NUM_LANES];
    logic signed [PW-1:0]        prod [NUM_LANES];

    logic                                a_valid_reg;
    logic [NUM_LANES-1:0][COEF_BITS-1:0] a_coef_reg;
    logic [NUM_LANES-1:0][PW-1:0]        a_prod_reg;

    logic signed [PW:0]                  det;
    logic [PW:0]                         dabs;
    logic signed [PW:0]                  num  [NUM_LANES];
    logic [PW:0]                         nabs [NUM_LANES];
    logic [NUM_LANES-1:0][NW-1:0]        num_next;
    logic [NUM_LANES-1:0]                qneg_next;

    ai2d_ctl_t                           ctl_reg;
    logic [NUM_LANES-1:0][COEF_BITS-1:0] coef_reg;
    logic [NUM_LANES-1:0][NW-1:0]        num_reg;
    logic [NUM_LANES-1:0]                qneg_reg;
    logic [PW-1:0]                       dmag_reg;

    // Read the low coefficient bits as signed and form the six products.
    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            sx[k] = in_word[k][COEF_BITS-1:0];
        end
        prod[0] = sx[0] * sx[3];
        prod[1] = sx[1] * sx[2];
        prod[2] = sx[2] * sx[5];
        prod[3] = sx[3] * sx[4];
        prod[4] = sx[1] * sx[4];
        prod[5] = sx[0] * sx[5];
    end

    // Product stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    // Product stage data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                a_coef_reg[k] <= sx[k];
                a_prod_reg[k] <= prod[k];
            end
        end
    end

    // Determinant, numerators, and their magnitudes scaled to the fixed-point format.
    always_comb
    begin
        det    = (PW+1)'($signed(a_prod_reg[0])) - (PW+1)'($signed(a_prod_reg[1]));
        dabs   = det[PW] ? -det : det;
        num[0] = (PW+1)'($signed(a_coef_reg[3]));
        num[1] = -((PW+1)'($signed(a_coef_reg[1])));
        num[2] = -((PW+1)'($signed(a_coef_reg[2])));
        num[3] = (PW+1)'($signed(a_coef_reg[0]));
        num[4] = (PW+1)'($signed(a_prod_reg[2])) - (PW+1)'($signed(a_prod_reg[3]));
        num[5] = (PW+1)'($signed(a_prod_reg[4])) - (PW+1)'($signed(a_prod_reg[5]));
        for (int k = 0; k < NUM_LANES; k++)
        begin
            nabs[k]      = num[k][PW] ? -num[k] : num[k];
            num_next[k]  = NW'(nabs[k][PW-1:0]) << ((k < 4) ? 2 * FRAC_BITS : FRAC_BITS);
            qneg_next[k] = num[k][PW] ^ det[PW];
        end
    end

    // Prepared stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
        begin
            ctl_reg.valid <= a_valid_reg;
            ctl_reg.sing  <= (det == '0);
        end
    end

    // Prepared stage data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= a_coef_reg;
            num_reg  <= num_next;
            qneg_reg <= qneg_next;
            dmag_reg <= dabs[PW-1:0];
        end
    end

    assign ctl     = ctl_reg;
    assign coef    = coef_reg;
    assign num_mag = num_reg;
    assign qneg    = qneg_reg;
    assign dmag    = dmag_reg;

endmodule

@@ rtl/ai2d_divider.sv @@
// Pipelined restoring divider: a range check, then one quotient bit per stage on six lanes.
module ai2d_divider
    import ai2d_pkg::*;
#(
    parameter  int COEF_BITS = 32,
    parameter  int FRAC_BITS = 16,
    localparam int PW        = 2 * COEF_BITS,
    localparam int NW        = PW + 2 * FRAC_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  ai2d_ctl_t                             in_ctl,
    input  logic [NUM_LANES-1:0][COEF_BITS-1:0]   in_coef,
    input  logic [NUM_LANES-1:0][NW-1:0]          num_mag,
    input  logic [NUM_LANES-1:0]                  in_qneg,
    input  logic [PW-1:0]                         dmag,
    output ai2d_ctl_t                             out_ctl,
    output logic [NUM_LANES-1:0][COEF_BITS-1:0]   out_coef,
    output logic [NUM_LANES-1:0][COEF_BITS-1:0]   quot,
    output logic [NUM_LANES-1:0]                  out_qneg,
    output logic [NUM_LANES-1:0]                  pre_ovf
);

    // Wide enough for the numerator and for the divisor at its largest shift.
    localparam int XW = (NW > 3 * COEF_BITS) ? NW : 3 * COEF_BITS;
    localparam int NS = COEF_BITS;

    ai2d_ctl_t                           ctl_reg  [NS+1];
    logic [NUM_LANES-1:0][COEF_BITS-1:0] coef_reg [NS+1];
    logic [NUM_LANES-1:0][COEF_BITS-1:0] quot_reg [NS+1];
    logic [NUM_LANES-1:0]                qneg_reg [NS+1];
    logic [NUM_LANES-1:0]                ovf_reg  [NS+1];
    logic [NUM_LANES-1:0][XW-1:0]        rem_reg  [NS];
    logic [PW-1:0]                       dmag_reg [NS];

    logic [XW-1:0]                       dtop;
    logic [NUM_LANES-1:0]                ovf_next;

    // A quotient that needs more than COEF_BITS bits saturates in any case.
    always_comb
    begin
        dtop = XW'(dmag) << COEF_BITS;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            ovf_next[k] = XW'(num_mag[k]) >= dtop;
        end
    end

    // Range check stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else if (en)
            ctl_reg[0] <= in_ctl;
    end

    // Range check stage data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg[0] <= in_coef;
            quot_reg[0] <= '0;
            qneg_reg[0] <= in_qneg;
            ovf_reg[0]  <= ovf_next;
            dmag_reg[0] <= dmag;
            for (int k = 0; k < NUM_LANES; k++)
            begin
                rem_reg[0][k] <= XW'(num_mag[k]);
            end
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < NS; s++)
    begin : g_step
        logic [XW-1:0]                       dsh;
        logic [NUM_LANES-1:0]                take;
        logic [NUM_LANES-1:0][XW-1:0]        rem_next;
        logic [NUM_LANES-1:0][COEF_BITS-1:0] quot_next;

        always_comb
        begin
            dsh = XW'(dmag_reg[s]) << (NS - 1 - s);
            for (int k = 0; k < NUM_LANES; k++)
            begin
                take[k]      = rem_reg[s][k] >= dsh;
                rem_next[k]  = take[k] ? rem_reg[s][k] - dsh : rem_reg[s][k];
                quot_next[k] = quot_reg[s][k];
                quot_next[k][NS-1-s] = take[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[s+1] <= '0;
            else if (en)
                ctl_reg[s+1] <= ctl_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                coef_reg[s+1] <= coef_reg[s];
                quot_reg[s+1] <= quot_next;
                qneg_reg[s+1] <= qneg_reg[s];
                ovf_reg[s+1]  <= ovf_reg[s];
            end
        end

        // The last stage needs no remainder or divisor after it.
        if (s < NS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1]  <= rem_next;
                    dmag_reg[s+1] <= dmag_reg[s];
                end
            end
        end
    end

    assign out_ctl  = ctl_reg[NS];
    assign out_coef = coef_reg[NS];
    assign quot     = quot_reg[NS];
    assign out_qneg = qneg_reg[NS];
    assign pre_ovf  = ovf_reg[NS];

endmodule

@@ rtl/ai2d_back.sv @@
// Back end: sign, saturation, singular bypass and the output register.
module ai2d_back
    import ai2d_pkg::*;
#(
    parameter int COEF_BITS = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  ai2d_ctl_t                             ctl,
    input  logic [NUM_LANES-1:0][COEF_BITS-1:0]   coef,
    input  logic [NUM_LANES-1:0][COEF_BITS-1:0]   quot,
    input  logic [NUM_LANES-1:0]                  qneg,
    input  logic [NUM_LANES-1:0]                  pre_ovf,
    output logic                                  out_valid,
    output logic [NUM_LANES-1:0][FIELD_BITS-1:0]  result,
    output logic                                  singular,
    output logic                                  overflow
);

    localparam logic [COEF_BITS-1:0] SAT_NEG = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic [COEF_BITS-1:0] SAT_POS = ~SAT_NEG;

    logic [COEF_BITS-1:0]                 val [NUM_LANES];
    logic [NUM_LANES-1:0]                 sat;
    logic [NUM_LANES-1:0][FIELD_BITS-1:0] result_next;

    logic                                 valid_reg;
    logic [NUM_LANES-1:0][FIELD_BITS-1:0] result_reg;
    logic                                 sing_reg;
    logic                                 ovf_reg;

    // Apply the sign, clamp to the signed coefficient range, or pass a singular matrix through.
    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            sat[k] = 1'b0;
            if (pre_ovf[k])
            begin
                val[k] = qneg[k] ? SAT_NEG : SAT_POS;
                sat[k] = 1'b1;
            end
            else if (qneg[k])
            begin
                if (quot[k] > SAT_NEG)
                begin
                    val[k] = SAT_NEG;
                    sat[k] = 1'b1;
                end
                else
                    val[k] = -quot[k];
            end
            else if (quot[k] > SAT_POS)
            begin
                val[k] = SAT_POS;
                sat[k] = 1'b1;
            end
            else
                val[k] = quot[k];
            result_next[k] = ctl.sing ? FIELD_BITS'($signed(coef[k]))
                                      : FIELD_BITS'($signed(val[k]));
        end
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ctl.valid;
    end

    // Output data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            sing_reg   <= ctl.sing;
            ovf_reg    <= !ctl.sing && (|sat);
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;
    assign singular  = sing_reg;
    assign overflow  = ovf_reg;

endmodule

@@ rtl/affine_2d_inverse.sv @@
// Top level of the pipelined 2D affine transform inverse.
//
// A request on the matrix channel carries the six coefficients a, b, c, d,
// tx and ty in signed fixed point (COEF_BITS wide, FRAC_BITS fraction bits,
// taken from the low bits of each field). The inverse channel returns one
// result per request in order: the six inverse coefficients, sign-extended
// to the field width, plus the singular and overflow flags.
// The pipeline has one product stage, one determinant stage, one range
// check, one stage per quotient bit of the six-lane restoring divider,
// and the output register.
// Throughput is one request per cycle while results are taken; the divider
// stages are fully pipelined; each stage takes a new request as it advances.
// When the receiver holds ready low with a result waiting, the whole
// pipeline holds in place and matrix.ready drops until the result is taken.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
`include "assert_macros.svh"

module affine_2d_inverse
    import ai2d_pkg::*;
#(
    parameter int COEF_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input logic              clk,
    input logic              rst_n,
    ai2d_in_if.sink          matrix,
    ai2d_out_if.source       inverse
);

    localparam int PW = 2 * COEF_BITS;
    localparam int NW = PW + 2 * FRAC_BITS;

    logic                                 en;
    logic [NUM_LANES-1:0][FIELD_BITS-1:0] in_word;

    ai2d_ctl_t                            f_ctl;
    logic [NUM_LANES-1:0][COEF_BITS-1:0]  f_coef;
    logic [NUM_LANES-1:0][NW-1:0]         f_num;
    logic [NUM_LANES-1:0]                 f_qneg;
    logic [PW-1:0]                        f_dmag;

    ai2d_ctl_t                            d_ctl;
    logic [NUM_LANES-1:0][COEF_BITS-1:0]  d_coef;
    logic [NUM_LANES-1:0][COEF_BITS-1:0]  d_quot;
    logic [NUM_LANES-1:0]                 d_qneg;
    logic [NUM_LANES-1:0]                 d_ovf;

    logic                                 out_valid;
    logic [NUM_LANES-1:0][FIELD_BITS-1:0] result;

    // The pipeline advances unless a finished result is waiting and not taken.
    assign en           = !out_valid || inverse.ready;
    assign matrix.ready = en;

    assign in_word[0] = matrix.coef_a;
    assign in_word[1] = matrix.coef_b;
    assign in_word[2] = matrix.coef_c;
    assign in_word[3] = matrix.coef_d;
    assign in_word[4] = matrix.offset_x;
    assign in_word[5] = matrix.offset_y;

    ai2d_front #(
        .COEF_BITS (COEF_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (matrix.valid),
        .in_word  (in_word),
        .ctl      (f_ctl),
        .coef     (f_coef),
        .num_mag  (f_num),
        .qneg     (f_qneg),
        .dmag     (f_dmag)
    );

    ai2d_divider #(
        .COEF_BITS (COEF_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_ctl   (f_ctl),
        .in_coef  (f_coef),
        .num_mag  (f_num),
        .in_qneg  (f_qneg),
        .dmag     (f_dmag),
        .out_ctl  (d_ctl),
        .out_coef (d_coef),
        .quot     (d_quot),
        .out_qneg (d_qneg),
        .pre_ovf  (d_ovf)
    );

    ai2d_back #(
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl       (d_ctl),
        .coef      (d_coef),
        .quot      (d_quot),
        .qneg      (d_qneg),
        .pre_ovf   (d_ovf),
        .out_valid (out_valid),
        .result    (result),
        .singular  (inverse.singular),
        .overflow  (inverse.overflow)
    );

    assign inverse.valid        = out_valid;
    assign inverse.inv_a        = result[0];
    assign inverse.inv_b        = result[1];
    assign inverse.inv_c        = result[2];
    assign inverse.inv_d        = result[3];
    assign inverse.inv_offset_x = result[4];
    assign inverse.inv_offset_y = result[5];

    // A singular matrix is passed through and never reports saturation.
    `AI2D_ASSERT_SAME(a_sing_no_ovf, inverse.valid && inverse.singular, !inverse.overflow)
    // A waiting result blocks new requests.
    `AI2D_ASSERT_SAME(a_stall_blocks, inverse.valid && !inverse.ready, !matrix.ready)
    // A result that is not taken is still offered in the next cycle.
    `AI2D_ASSERT_NEXT(a_stall_keeps, inverse.valid && !inverse.ready, inverse.valid)

endmodule

@@ verif/affine_2d_inverse_tb.sv @@
// Self-checking testbench of the 2D affine transform inverse block.
module affine_2d_inverse_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 36;
    localparam int FRAC = 16;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN = 120;

    // One inverse result as it should come out of the block.
    typedef struct {
        logic signed [31:0] lane [6];
        logic               sing;
        logic               ovf;
    } inverse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ai2d_in_if  matrix_ch ();
    ai2d_out_if inverse_ch ();

    affine_2d_inverse DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .matrix  (matrix_ch.sink),
        .inverse (inverse_ch.source)
    );

    inverse_t expected_q [$];
    int       errors = 0;
    int       results_seen = 0;
    int       requests_sent = 0;
    int       singular_seen = 0;
    int       overflow_seen = 0;
    longint   cycles = 0;
    bit       src_idle_en = 1'b1;
    bit       sink_idle_en = 1'b1;
    int       hold_requests = 0;
    int       hold_served = 0;
    int       hold_cycles = 0;

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Numerator times 2^shift over the determinant, truncated toward zero and saturated.
    function automatic logic signed [31:0] sat_quot(input logic signed [127:0] num,
                                                    input int shift,
                                                    input logic signed [127:0] det,
                                                    inout logic ovf);
        logic signed [127:0] q;
        q = (num <<< shift) / det;
        if (q > 128'sd2147483647)
        begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -128'sd2147483648)
        begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    // Works out the inverse of one matrix.
    function automatic inverse_t invert_affine(input logic signed [31:0] m [6]);
        inverse_t r;
        logic signed [127:0] a, b, c, d, tx, ty, det;
        logic ovf;
        a = m[0]; b = m[1]; c = m[2]; d = m[3]; tx = m[4]; ty = m[5];
        det = a * d - b * c;
        ovf = 1'b0;
        r.sing = (det == 0);
        if (r.sing)
        begin
            for (int k = 0; k < 6; k++)
                r.lane[k] = m[k];
        end
        else
        begin
            r.lane[0] = sat_quot(d, 2 * FRAC, det, ovf);
            r.lane[1] = sat_quot(-b, 2 * FRAC, det, ovf);
            r.lane[2] = sat_quot(-c, 2 * FRAC, det, ovf);
            r.lane[3] = sat_quot(a, 2 * FRAC, det, ovf);
            r.lane[4] = sat_quot(c * ty - d * tx, FRAC, det, ovf);
            r.lane[5] = sat_quot(b * tx - a * ty, FRAC, det, ovf);
        end
        r.ovf = ovf;
        return r;
    endfunction

    // Sends one matrix request, idling at random before it.
    task automatic send_matrix(input logic signed [31:0] m [6]);
        while (src_idle_en && $urandom_range(99) < 37)
        begin
            matrix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        matrix_ch.valid    <= 1'b1;
        matrix_ch.coef_a   <= m[0];
        matrix_ch.coef_b   <= m[1];
        matrix_ch.coef_c   <= m[2];
        matrix_ch.coef_d   <= m[3];
        matrix_ch.offset_x <= m[4];
        matrix_ch.offset_y <= m[5];
        do
            @(posedge clk);
        while (!matrix_ch.ready);
        expected_q.push_back(invert_affine(m));
        requests_sent++;
    endtask

    function automatic logic signed [31:0] rand_field(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(8)) <<< ($urandom_range(15) + 10);
            2: return $signed(32'(int'($urandom_range(2 * 65536)) - 65536));
            3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed(32'(int'($urandom_range(64)) - 32));
        endcase
    endfunction

    task automatic send_random(input int count);
        logic signed [31:0] m [6];
        int mode;
        repeat (count)
        begin
            mode = $urandom_range(4);
            for (int k = 0; k < 6; k++)
                m[k] = rand_field($urandom_range(9) < 7 ? mode : $urandom_range(4));
            // Now and then make the determinant zero on purpose.
            if ($urandom_range(9) == 0)
            begin
                m[2] = m[0];
                m[3] = m[1];
            end
            send_matrix(m);
        end
    endtask

    // Extremes, identity, singular and overflowing matrices.
    task automatic test_directed();
        logic signed [31:0] m [6];
        logic signed [31:0] ext [5];
        ext = '{32'sh7fffffff, 32'sh80000000, 32'sh00010000, 32'sh0, 32'shffffffff};
        m = '{32'sh10000, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0};
        send_matrix(m);
        m = '{32'sh10000, 32'sh0, 32'sh0, 32'sh10000, 32'sh7fffffff, 32'sh80000000};
        send_matrix(m);
        m = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh1234, 32'sh80000000};
        send_matrix(m);
        m = '{32'sh20000, 32'sh40000, 32'sh10000, 32'sh20000, 32'sh5, 32'sh6};
        send_matrix(m);
        m = '{32'sh1, 32'sh0, 32'sh0, 32'sh1, 32'sh10000, 32'sh10000};
        send_matrix(m);
        m = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000};
        send_matrix(m);
        m = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff};
        send_matrix(m);
        for (int i = 0; i < 15; i++)
        begin
            for (int k = 0; k < 6; k++)
                m[k] = ext[(i + k * (i / 5 + 1)) % 5];
            send_matrix(m);
        end
    endtask

    // Back-to-back requests while the receiver holds off.
    task automatic test_backpressure();
        src_idle_en = 1'b0;
        hold_requests++;
        send_random(200);
        src_idle_en = 1'b1;
    endtask

    task automatic test_no_idle();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        send_random(250);
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Receiver ready: random idling, plus a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inverse_ch.ready <= 1'b0;
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_cycles <= HOLD_LEN - 1;
            inverse_ch.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            inverse_ch.ready <= 1'b0;
        end
        else
            inverse_ch.ready <= !(sink_idle_en && $urandom_range(99) < 37);
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        inverse_t exp_r;
        logic signed [31:0] got [6];
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && inverse_ch.valid && inverse_ch.ready)
        begin
            got = '{inverse_ch.inv_a, inverse_ch.inv_b, inverse_ch.inv_c,
                    inverse_ch.inv_d, inverse_ch.inv_offset_x, inverse_ch.inv_offset_y};
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result", $time);
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                results_seen++;
                if (exp_r.sing) singular_seen++;
                if (exp_r.ovf) overflow_seen++;
                for (int k = 0; k < 6; k++)
                    if (got[k] !== exp_r.lane[k])
                    begin
                        $display("%0t: lane %0d expected %h actual %h",
                                 $time, k, exp_r.lane[k], got[k]);
                        errors++;
                    end
                if (inverse_ch.singular !== exp_r.sing)
                begin
                    $display("%0t: singular expected %b actual %b",
                             $time, exp_r.sing, inverse_ch.singular);
                    errors++;
                end
                if (inverse_ch.overflow !== exp_r.ovf)
                begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, exp_r.ovf, inverse_ch.overflow);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        matrix_ch.valid = 1'b0;
        matrix_ch.coef_a = '0;
        matrix_ch.coef_b = '0;
        matrix_ch.coef_c = '0;
        matrix_ch.coef_d = '0;
        matrix_ch.offset_x = '0;
        matrix_ch.offset_y = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_random(500);
        test_backpressure();
        test_no_idle();
        send_random(580);
        matrix_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated).",
                 requests_sent, results_seen, singular_seen, overflow_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
